[hw/rtl/dafp_pkg.sv]
// Shared widths, flag word and helper functions for the dihedral angle datapath.
package dafp_pkg;

    localparam int CW_DEFAULT   = 20;
    localparam int AF_DEFAULT   = 8;
    localparam int DIFF_W       = 21;
    localparam int DIFF_LIM     = 20;
    localparam int NRM_W        = 42;
    localparam int SPLIT        = 21;
    localparam int T_W          = 66;
    localparam int SH_W         = 31;
    localparam int NRM_LIM      = 30;
    localparam int PRD_W        = 62;
    localparam int XM_W         = 64;
    localparam int SQ_W         = 62;
    localparam int ROOT_W       = 31;
    localparam int MAG_W        = 30;
    localparam int PRE_TOP      = 30;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 33;
    localparam int TH_W         = 33;
    localparam int ACC_FRAC     = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int HALF_TURN    = 180;
    localparam int RIGHT_ANGLE  = 90;
    localparam int TORS_W       = 17;
    localparam int BL_W         = 7;

    typedef struct packed {
        logic deg;
        logic tzero;
        logic tneg;
        logic xneg;
        logic yzero;
        logic xzero;
    } flags_t;

    function automatic logic [BL_W-1:0] bitlen(input logic [63:0] v);
        logic [BL_W-1:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) r = BL_W'(i + 1);
        end
        return r;
    endfunction

    function automatic logic [BL_W-1:0] fit_amt(input logic [63:0] v,
                                                input logic [BL_W-1:0] lim);
        logic [BL_W-1:0] bl;
        bl = bitlen(v);
        return (bl > lim) ? bl - lim : '0;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // shift magnitude right, rounding toward zero
    function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v,
                                                       input logic [BL_W-1:0] s);
        logic [63:0] m;
        m = mag64(v) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [CZ_W-1:0] atan_deg(input int unsigned i);
        logic signed [CZ_W-1:0] r;
        case (i)
            0:  r = CZ_W'(754974720);
            1:  r = CZ_W'(445687602);
            2:  r = CZ_W'(235489088);
            3:  r = CZ_W'(119537938);
            4:  r = CZ_W'(60000934);
            5:  r = CZ_W'(30029717);
            6:  r = CZ_W'(15018523);
            7:  r = CZ_W'(7509720);
            8:  r = CZ_W'(3754917);
            9:  r = CZ_W'(1877466);
            10: r = CZ_W'(938734);
            11: r = CZ_W'(469367);
            12: r = CZ_W'(234684);
            13: r = CZ_W'(117342);
            14: r = CZ_W'(58671);
            15: r = CZ_W'(29335);
            16: r = CZ_W'(14668);
            17: r = CZ_W'(7334);
            18: r = CZ_W'(3667);
            19: r = CZ_W'(1833);
            20: r = CZ_W'(917);
            21: r = CZ_W'(458);
            22: r = CZ_W'(229);
            23: r = CZ_W'(115);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/dafp_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module dafp_isqrt
    import dafp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SQ_W-1:0]     in_sq,
    input  logic [MAG_W-1:0]    in_ax,
    input  flags_t              in_flags,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output logic [MAG_W-1:0]    out_ax,
    output flags_t              out_flags
);

    localparam int RW = SQ_W + 1;

    logic [RW-1:0]    v_reg   [ROOT_W];
    logic [RW-1:0]    r_reg   [ROOT_W];
    logic [MAG_W-1:0] ax_reg  [ROOT_W];
    flags_t           f_reg   [ROOT_W];
    logic             vld_reg [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int BP = 2 * (ROOT_W - 1 - g);
        logic [RW-1:0]    v_in, r_in, trial, v_next, r_next;
        logic [MAG_W-1:0] ax_in;
        flags_t           f_in;
        logic             vld_in;

        if (g == 0) begin : g_first
            assign v_in   = RW'(in_sq);
            assign r_in   = '0;
            assign ax_in  = in_ax;
            assign f_in   = in_flags;
            assign vld_in = in_valid;
        end else begin : g_rest
            assign v_in   = v_reg[g-1];
            assign r_in   = r_reg[g-1];
            assign ax_in  = ax_reg[g-1];
            assign f_in   = f_reg[g-1];
            assign vld_in = vld_reg[g-1];
        end

        always_comb begin
            trial = r_in + (RW'(1) << BP);
            if (v_in >= trial) begin
                v_next = v_in - trial;
                r_next = (r_in >> 1) + (RW'(1) << BP);
            end else begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[g]  <= v_next;
                r_reg[g]  <= r_next;
                ax_reg[g] <= ax_in;
                f_reg[g]  <= f_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = r_reg[ROOT_W-1][ROOT_W-1:0];
    assign out_ax    = ax_reg[ROOT_W-1];
    assign out_flags = f_reg[ROOT_W-1];

endmodule

[hw/rtl/dafp_cordic.sv]
// Pipelined CORDIC vectoring, one rotation per stage, angle in degrees.
module dafp_cordic
    import dafp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [CX_W-1:0] in_x,
    input  logic signed [CX_W-1:0] in_y,
    input  flags_t                 in_flags,
    output logic                   out_valid,
    output logic signed [CZ_W-1:0] out_z,
    output flags_t                 out_flags
);

    logic signed [CX_W-1:0] x_reg   [CORDIC_STEPS];
    logic signed [CX_W-1:0] y_reg   [CORDIC_STEPS];
    logic signed [CZ_W-1:0] z_reg   [CORDIC_STEPS];
    flags_t                 f_reg   [CORDIC_STEPS];
    logic                   vld_reg [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        logic signed [CX_W-1:0] x_in, y_in, x_next, y_next;
        logic signed [CZ_W-1:0] z_in, z_next;
        flags_t                 f_in;
        logic                   vld_in;

        if (g == 0) begin : g_first
            assign x_in   = in_x;
            assign y_in   = in_y;
            assign z_in   = '0;
            assign f_in   = in_flags;
            assign vld_in = in_valid;
        end else begin : g_rest
            assign x_in   = x_reg[g-1];
            assign y_in   = y_reg[g-1];
            assign z_in   = z_reg[g-1];
            assign f_in   = f_reg[g-1];
            assign vld_in = vld_reg[g-1];
        end

        always_comb begin
            if (!y_in[CX_W-1]) begin
                x_next = x_in + (y_in >>> g);
                y_next = y_in - (x_in >>> g);
                z_next = z_in + atan_deg(g);
            end else begin
                x_next = x_in - (y_in >>> g);
                y_next = y_in + (x_in >>> g);
                z_next = z_in - atan_deg(g);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[g] <= x_next;
                y_reg[g] <= y_next;
                z_reg[g] <= z_next;
                f_reg[g] <= f_in;
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_STEPS-1];
    assign out_z     = z_reg[CORDIC_STEPS-1];
    assign out_flags = f_reg[CORDIC_STEPS-1];

endmodule

[hw/rtl/dihedral_angle_from_four_points.sv]
// Dihedral angle of four 3-D points: fully pipelined, one word in and one word out.
// Pipeline: 13 vector, 31 square-root, 2 prescale, 24 CORDIC and 2 output stages.
// Throughput: one word per cycle; the whole pipeline holds while the output is stalled.
// Reset clears all valid bits; data registers are not reset.
module dihedral_angle_from_four_points
    import dafp_pkg::*;
#(
    parameter int COORD_WIDTH     = CW_DEFAULT,
    parameter int ANGLE_FRAC_BITS = AF_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // torsion_deg
    output logic [((TORS_W+7)/8)*8-1:0]            m_tdata,
    // degenerate
    output logic                                   m_tuser
);

    localparam int DW      = COORD_WIDTH + 1;
    localparam int MDATA_W = ((TORS_W + 7) / 8) * 8;
    localparam int HP_W    = DIFF_W + NRM_W - SPLIT;
    localparam int LP_W    = DIFF_W + SPLIT + 1;
    localparam int RND_SH  = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [CZ_W-1:0] RIGHT_Z =
        CZ_W'(longint'(RIGHT_ANGLE) << ACC_FRAC);
    localparam logic [TH_W-1:0] HALF_TH = TH_W'(longint'(HALF_TURN) << ACC_FRAC);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic v_reg [1:13];

    logic signed [COORD_WIDTH-1:0] pt [12];
    logic signed [DW-1:0] arm1_next [3], axs1_next [3], far1_next [3];
    logic signed [DW-1:0] arm1_reg [3], axs1_reg [3], far1_reg [3];
    logic signed [DW-1:0] arm2_reg [3], axs2_reg [3], far2_reg [3];
    logic [BL_W-1:0]      sd2_next, sd2_reg;
    logic signed [DIFF_W-1:0] arm3_next [3], axs3_next [3], far3_next [3];
    logic signed [DIFF_W-1:0] arm3_reg [3], axs3_reg [3], far3_reg [3];
    logic signed [NRM_W-1:0]  pa4_next [6], pf4_next [6], pa4_reg [6], pf4_reg [6];
    logic signed [DIFF_W-1:0] arm4_reg [3], arm5_reg [3];
    logic signed [NRM_W-1:0]  n1_5_next [3], n2_5_next [3], n1_5_reg [3], n2_5_reg [3];
    logic signed [NRM_W-1:0]  n1_6_reg [3], n2_6_reg [3];
    logic signed [HP_W-1:0]   ph6_next [3], ph6_reg [3];
    logic signed [LP_W-1:0]   pl6_next [3], pl6_reg [3];
    logic [BL_W-1:0]          s1_6_next, s2_6_next, s1_6_reg, s2_6_reg;
    logic                     deg6_next, deg6_reg, deg7_reg;
    logic signed [T_W-1:0]    t7_next, t7_reg;
    logic signed [SH_W-1:0]   n1_7_next [3], n2_7_next [3], n1_7_reg [3], n2_7_reg [3];
    logic signed [PRD_W-1:0]  d8_next [3], q8_next [6], d8_reg [3], q8_reg [6];
    flags_t                   f8_next, f8_reg, f9_reg, f10_reg, f11_reg;
    flags_t                   f12_next, f12_reg, f13_reg;
    logic signed [XM_W-1:0]   x9_next, m9_next [3], x9_reg, m9_reg [3];
    logic signed [XM_W-1:0]   x10_reg, m10_reg [3];
    logic [BL_W-1:0]          s10_next, s10_reg;
    logic signed [SH_W-1:0]   x11_next, m11_next [3], x11_reg, m11_reg [3];
    logic signed [PRD_W-1:0]  sqm12_next [3], sqm12_reg [3];
    logic [MAG_W-1:0]         ax12_next, ax12_reg, ax13_reg;
    logic [SQ_W-1:0]          sq13_next, sq13_reg;

    logic                     sq_vld;
    logic [ROOT_W-1:0]        sq_root;
    logic [MAG_W-1:0]         sq_ax;
    flags_t                   sq_f;

    logic                     pre1_vld_reg, pre2_vld_reg;
    logic [MAG_W-1:0]         ax14_reg;
    logic [ROOT_W-1:0]        rt14_reg;
    logic [BL_W-1:0]          k14_next, k14_reg;
    flags_t                   f14_next, f14_reg, f15_reg;
    logic signed [CX_W-1:0]   x15_next, y15_next, x15_reg, y15_reg;

    logic                     cd_vld;
    logic signed [CZ_W-1:0]   cd_z;
    flags_t                   cd_f;

    logic                     fin_vld_reg;
    logic [TH_W-1:0]          th_next, th_reg;
    flags_t                   fo_reg;
    logic signed [CZ_W-1:0]   zc;
    logic [TH_W-1:0]          thq, rnd;
    logic [TORS_W-1:0]        tors_next, tors_reg;
    logic                     m_tvalid_reg, m_tuser_reg;

    logic [63:0] or2, or1, or2b, or10;

    always_comb begin
        for (int k = 0; k < 12; k++) begin
            pt[k] = s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
        end
        for (int a = 0; a < 3; a++) begin
            arm1_next[a] = DW'(pt[a])     - DW'(pt[3+a]);
            axs1_next[a] = DW'(pt[3+a])   - DW'(pt[6+a]);
            far1_next[a] = DW'(pt[9+a])   - DW'(pt[6+a]);
        end

        // common fit shift for the nine differences
        or2 = '0;
        for (int a = 0; a < 3; a++) begin
            or2 = or2 | mag64(64'(arm1_reg[a])) | mag64(64'(axs1_reg[a]))
                      | mag64(64'(far1_reg[a]));
        end
        sd2_next = fit_amt(or2, BL_W'(DIFF_LIM));

        for (int a = 0; a < 3; a++) begin
            arm3_next[a] = DIFF_W'(trunc_shift(64'(arm2_reg[a]), sd2_reg));
            axs3_next[a] = DIFF_W'(trunc_shift(64'(axs2_reg[a]), sd2_reg));
            far3_next[a] = DIFF_W'(trunc_shift(64'(far2_reg[a]), sd2_reg));
        end

        // n1 = axis x arm, n2 = axis x far
        pa4_next[0] = NRM_W'(axs3_reg[1]) * NRM_W'(arm3_reg[2]);
        pa4_next[1] = NRM_W'(axs3_reg[2]) * NRM_W'(arm3_reg[1]);
        pa4_next[2] = NRM_W'(axs3_reg[2]) * NRM_W'(arm3_reg[0]);
        pa4_next[3] = NRM_W'(axs3_reg[0]) * NRM_W'(arm3_reg[2]);
        pa4_next[4] = NRM_W'(axs3_reg[0]) * NRM_W'(arm3_reg[1]);
        pa4_next[5] = NRM_W'(axs3_reg[1]) * NRM_W'(arm3_reg[0]);
        pf4_next[0] = NRM_W'(axs3_reg[1]) * NRM_W'(far3_reg[2]);
        pf4_next[1] = NRM_W'(axs3_reg[2]) * NRM_W'(far3_reg[1]);
        pf4_next[2] = NRM_W'(axs3_reg[2]) * NRM_W'(far3_reg[0]);
        pf4_next[3] = NRM_W'(axs3_reg[0]) * NRM_W'(far3_reg[2]);
        pf4_next[4] = NRM_W'(axs3_reg[0]) * NRM_W'(far3_reg[1]);
        pf4_next[5] = NRM_W'(axs3_reg[1]) * NRM_W'(far3_reg[0]);

        for (int a = 0; a < 3; a++) begin
            n1_5_next[a] = pa4_reg[2*a] - pa4_reg[2*a+1];
            n2_5_next[a] = pf4_reg[2*a] - pf4_reg[2*a+1];
        end

        // sign product t = arm . n2, n2 split into high and low halves
        deg6_next = (n1_5_reg[0] == '0 && n1_5_reg[1] == '0 && n1_5_reg[2] == '0) ||
                    (n2_5_reg[0] == '0 && n2_5_reg[1] == '0 && n2_5_reg[2] == '0);
        or1  = '0;
        or2b = '0;
        for (int a = 0; a < 3; a++) begin
            ph6_next[a] = HP_W'(arm5_reg[a]) *
                          HP_W'($signed(n2_5_reg[a][NRM_W-1:SPLIT]));
            pl6_next[a] = LP_W'(arm5_reg[a]) *
                          LP_W'($signed({1'b0, n2_5_reg[a][SPLIT-1:0]}));
            or1  = or1  | mag64(64'(n1_5_reg[a]));
            or2b = or2b | mag64(64'(n2_5_reg[a]));
        end
        s1_6_next = fit_amt(or1, BL_W'(NRM_LIM));
        s2_6_next = fit_amt(or2b, BL_W'(NRM_LIM));

        t7_next = ((T_W'(ph6_reg[0]) + T_W'(ph6_reg[1]) + T_W'(ph6_reg[2])) <<< SPLIT)
                + T_W'(pl6_reg[0]) + T_W'(pl6_reg[1]) + T_W'(pl6_reg[2]);
        for (int a = 0; a < 3; a++) begin
            n1_7_next[a] = SH_W'(trunc_shift(64'(n1_6_reg[a]), s1_6_reg));
            n2_7_next[a] = SH_W'(trunc_shift(64'(n2_6_reg[a]), s2_6_reg));
        end

        f8_next       = '0;
        f8_next.deg   = deg7_reg;
        f8_next.tzero = (t7_reg == '0);
        f8_next.tneg  = t7_reg[T_W-1];
        for (int a = 0; a < 3; a++) begin
            d8_next[a] = PRD_W'(n1_7_reg[a]) * PRD_W'(n2_7_reg[a]);
        end
        q8_next[0] = PRD_W'(n1_7_reg[1]) * PRD_W'(n2_7_reg[2]);
        q8_next[1] = PRD_W'(n1_7_reg[2]) * PRD_W'(n2_7_reg[1]);
        q8_next[2] = PRD_W'(n1_7_reg[2]) * PRD_W'(n2_7_reg[0]);
        q8_next[3] = PRD_W'(n1_7_reg[0]) * PRD_W'(n2_7_reg[2]);
        q8_next[4] = PRD_W'(n1_7_reg[0]) * PRD_W'(n2_7_reg[1]);
        q8_next[5] = PRD_W'(n1_7_reg[1]) * PRD_W'(n2_7_reg[0]);

        x9_next = XM_W'(d8_reg[0]) + XM_W'(d8_reg[1]) + XM_W'(d8_reg[2]);
        for (int a = 0; a < 3; a++) begin
            m9_next[a] = XM_W'(q8_reg[2*a]) - XM_W'(q8_reg[2*a+1]);
        end

        or10 = mag64(x9_reg);
        for (int a = 0; a < 3; a++) begin
            or10 = or10 | mag64(m9_reg[a]);
        end
        s10_next = fit_amt(or10, BL_W'(NRM_LIM));

        x11_next = SH_W'(trunc_shift(x10_reg, s10_reg));
        for (int a = 0; a < 3; a++) begin
            m11_next[a] = SH_W'(trunc_shift(m10_reg[a], s10_reg));
        end

        for (int a = 0; a < 3; a++) begin
            sqm12_next[a] = PRD_W'(m11_reg[a]) * PRD_W'(m11_reg[a]);
        end
        f12_next      = f11_reg;
        f12_next.xneg = x11_reg[SH_W-1];
        ax12_next     = x11_reg[SH_W-1] ? MAG_W'(-x11_reg) : MAG_W'(x11_reg);

        sq13_next = SQ_W'(sqm12_reg[0]) + SQ_W'(sqm12_reg[1]) + SQ_W'(sqm12_reg[2]);

        // prescale: bring the larger of |x|, y up to bit PRE_TOP-1
        f14_next       = sq_f;
        f14_next.yzero = (sq_root == '0);
        f14_next.xzero = (sq_ax == '0);
        k14_next = BL_W'(PRE_TOP) - bitlen(64'(ROOT_W'(sq_ax) | sq_root));
        if (bitlen(64'(ROOT_W'(sq_ax) | sq_root)) >= BL_W'(PRE_TOP)) k14_next = '0;

        x15_next = CX_W'(ax14_reg) << k14_reg;
        y15_next = CX_W'(rt14_reg) << k14_reg;

        if (cd_z[CZ_W-1])        zc = '0;
        else if (cd_z > RIGHT_Z) zc = RIGHT_Z;
        else                     zc = cd_z;
        if (cd_f.yzero)          thq = '0;
        else if (cd_f.xzero)     thq = TH_W'(RIGHT_Z);
        else                     thq = TH_W'(zc);
        th_next = cd_f.xneg ? HALF_TH - thq : thq;

        rnd = (th_reg + (TH_W'(1) << (RND_SH - 1))) >> RND_SH;
        if (fo_reg.deg || fo_reg.tzero) tors_next = '0;
        else if (fo_reg.tneg)           tors_next = -TORS_W'(rnd);
        else                            tors_next = TORS_W'(rnd);
    end

    dafp_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_reg[13]),
        .in_sq     (sq13_reg),
        .in_ax     (ax13_reg),
        .in_flags  (f13_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_ax    (sq_ax),
        .out_flags (sq_f)
    );

    dafp_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pre2_vld_reg),
        .in_x      (x15_reg),
        .in_y      (y15_reg),
        .in_flags  (f15_reg),
        .out_valid (cd_vld),
        .out_z     (cd_z),
        .out_flags (cd_f)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= 13; k++) v_reg[k] <= 1'b0;
            pre1_vld_reg <= 1'b0;
            pre2_vld_reg <= 1'b0;
            fin_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v_reg[1] <= s_tvalid;
            for (int k = 2; k <= 13; k++) v_reg[k] <= v_reg[k-1];
            pre1_vld_reg <= sq_vld;
            pre2_vld_reg <= pre1_vld_reg;
            fin_vld_reg  <= cd_vld;
            m_tvalid_reg <= fin_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            arm1_reg <= arm1_next;
            axs1_reg <= axs1_next;
            far1_reg <= far1_next;
            arm2_reg <= arm1_reg;
            axs2_reg <= axs1_reg;
            far2_reg <= far1_reg;
            sd2_reg  <= sd2_next;
            arm3_reg <= arm3_next;
            axs3_reg <= axs3_next;
            far3_reg <= far3_next;
            pa4_reg  <= pa4_next;
            pf4_reg  <= pf4_next;
            arm4_reg <= arm3_reg;
            n1_5_reg <= n1_5_next;
            n2_5_reg <= n2_5_next;
            arm5_reg <= arm4_reg;
            n1_6_reg <= n1_5_reg;
            n2_6_reg <= n2_5_reg;
            ph6_reg  <= ph6_next;
            pl6_reg  <= pl6_next;
            s1_6_reg <= s1_6_next;
            s2_6_reg <= s2_6_next;
            deg6_reg <= deg6_next;
            t7_reg   <= t7_next;
            n1_7_reg <= n1_7_next;
            n2_7_reg <= n2_7_next;
            deg7_reg <= deg6_reg;
            d8_reg   <= d8_next;
            q8_reg   <= q8_next;
            f8_reg   <= f8_next;
            x9_reg   <= x9_next;
            m9_reg   <= m9_next;
            f9_reg   <= f8_reg;
            x10_reg  <= x9_reg;
            m10_reg  <= m9_reg;
            s10_reg  <= s10_next;
            f10_reg  <= f9_reg;
            x11_reg  <= x11_next;
            m11_reg  <= m11_next;
            f11_reg  <= f10_reg;
            sqm12_reg <= sqm12_next;
            ax12_reg <= ax12_next;
            f12_reg  <= f12_next;
            sq13_reg <= sq13_next;
            ax13_reg <= ax12_reg;
            f13_reg  <= f12_reg;
            ax14_reg <= sq_ax;
            rt14_reg <= sq_root;
            k14_reg  <= k14_next;
            f14_reg  <= f14_next;
            x15_reg  <= x15_next;
            y15_reg  <= y15_next;
            f15_reg  <= f14_reg;
            th_reg   <= th_next;
            fo_reg   <= cd_f;
            tors_reg <= tors_next;
            m_tuser_reg <= fo_reg.deg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = MDATA_W'(tors_reg);
    assign m_tuser  = m_tuser_reg;

endmodule
